/* rtl/core/ags_pkg.sv */
// ----------------------------------------------------------------------------
// ags_pkg
// shared types and constants for the argsort engine
// ----------------------------------------------------------------------------
package ags_pkg;

    localparam int VALUE_W = 32;
    localparam int IDX_W   = 6;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } ags_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]          index;
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      final_res;
        logic                      overflow;
    } ags_out_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RANK_FETCH,
        ST_RANK_PIVOT,
        ST_RANK_CMP,
        ST_RANK_WRITE,
        ST_EMIT_RD,
        ST_EMIT_SHOW
    } ags_state_t;

endpackage

/* rtl/core/ags_rank_cmp.sv */
// ----------------------------------------------------------------------------
// ags_rank_cmp
// shared compare unit: does entry a sort strictly before entry b
// ----------------------------------------------------------------------------
module ags_rank_cmp
    import ags_pkg::*;
(
    input  logic signed [VALUE_W-1:0] a_value,
    input  logic [IDX_W-1:0]          a_idx,
    input  logic signed [VALUE_W-1:0] b_value,
    input  logic [IDX_W-1:0]          b_idx,
    output logic                      a_before_b
);

    // signed value first, smaller arrival index breaks ties
    always_comb
    begin
        if (a_value != b_value)
        begin
            a_before_b = (a_value < b_value);
        end
        else
        begin
            a_before_b = (a_idx < b_idx);
        end
    end

endmodule

/* rtl/core/argsort_engine_top.sv */
// ----------------------------------------------------------------------------
// argsort_engine_top
// Loading takes one item per cycle. After the item marked last, each of the n
//   stored elements is ranked in turn (fetch, pivot, compare with all n, write),
//   then results go out one at a time (memory read, then output register).
// Throughput is set by the single shared compare unit and the one read port
//   of the value memory. Reset clears the sequencer, element count, overflow
//   flag and order bit; working registers and both memories are not cleared.
// ----------------------------------------------------------------------------
module argsort_engine_top
    import ags_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic     clk,
    input  logic     rst_n,

    input  logic     cfg_wr_en,
    input  logic     cfg_wr_data,

    input  logic     in_valid,
    output logic     in_stall,
    input  ags_in_t  in_data,

    output logic     out_valid,
    input  logic     out_stall,
    output ags_out_t out_data
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // value memory holds the set in arrival order, so address = arrival index
    logic signed [VALUE_W-1:0] value_mem [DEPTH];
    // sorted memory holds {arrival index, value} at each element's rank
    logic [AW+VALUE_W-1:0]     sort_mem  [DEPTH];

    ags_state_t state_reg, state_next;

    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic                      desc_reg;
    logic [AW-1:0]             last_pos_reg, last_pos_next;   // n - 1
    logic [AW-1:0]             pivot_idx_reg, pivot_idx_next; // element being ranked
    logic signed [VALUE_W-1:0] pivot_val_reg, pivot_val_next;
    logic [AW-1:0]             cmp_idx_reg, cmp_idx_next;     // address of data in flight
    logic [AW-1:0]             rank_reg, rank_next;
    logic [AW-1:0]             emit_k_reg, emit_k_next;

    // memory ports
    logic                      val_wr_en;
    logic [AW-1:0]             val_wr_addr;
    logic [AW-1:0]             val_rd_addr;
    logic signed [VALUE_W-1:0] val_rd_data_reg;
    logic                      sort_wr_en;
    logic                      sort_rd_en;
    logic [AW-1:0]             sort_rd_addr;
    logic [AW+VALUE_W-1:0]     sort_rd_data_reg;

    logic                      in_accept;
    logic                      out_accept;
    logic                      has_room;
    logic                      emit_final;
    logic                      cmp_before;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign has_room   = (count_reg < CNT_W'(DEPTH));
    assign emit_final = (emit_k_reg == last_pos_reg);

    // ------------------------------------------------------------------------
    // shared compare unit: element in flight against the pivot
    // ------------------------------------------------------------------------
    ags_rank_cmp u_cmp (
        .a_value    (val_rd_data_reg),
        .a_idx      (IDX_W'(cmp_idx_reg)),
        .b_value    (pivot_val_reg),
        .b_idx      (IDX_W'(pivot_idx_reg)),
        .a_before_b (cmp_before)
    );

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && in_data.last)
                begin
                    state_next = ST_RANK_FETCH;
                end
            end
            ST_RANK_FETCH:
            begin
                state_next = ST_RANK_PIVOT;
            end
            ST_RANK_PIVOT:
            begin
                state_next = ST_RANK_CMP;
            end
            ST_RANK_CMP:
            begin
                if (cmp_idx_reg == last_pos_reg)
                begin
                    state_next = ST_RANK_WRITE;
                end
            end
            ST_RANK_WRITE:
            begin
                if (pivot_idx_reg == last_pos_reg)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_RANK_FETCH;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_SHOW;
            end
            ST_EMIT_SHOW:
            begin
                if (out_accept)
                begin
                    state_next = emit_final ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // datapath control and handshake outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        last_pos_next  = last_pos_reg;
        pivot_idx_next = pivot_idx_reg;
        pivot_val_next = pivot_val_reg;
        cmp_idx_next   = cmp_idx_reg;
        rank_next      = rank_reg;
        emit_k_next    = emit_k_reg;

        in_stall     = 1'b1;
        out_valid    = 1'b0;
        val_wr_en    = 1'b0;
        val_wr_addr  = count_reg[AW-1:0];
        val_rd_addr  = pivot_idx_reg;
        sort_wr_en   = 1'b0;
        sort_rd_en   = 1'b0;
        sort_rd_addr = desc_reg ? (last_pos_reg - emit_k_reg) : emit_k_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                // stall is low while loading, so valid alone means accepted
                if (in_valid)
                begin
                    if (has_room)
                    begin
                        // store at the arrival position; full sets drop the item
                        val_wr_en  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_data.last)
                    begin
                        last_pos_next  = has_room ? count_reg[AW-1:0] : AW'(DEPTH - 1);
                        pivot_idx_next = '0;
                    end
                end
            end
            ST_RANK_FETCH:
            begin
                val_rd_addr = pivot_idx_reg;
            end
            ST_RANK_PIVOT:
            begin
                // pivot value arrives, start streaming the set from address 0
                pivot_val_next = val_rd_data_reg;
                val_rd_addr    = '0;
                cmp_idx_next   = '0;
                rank_next      = '0;
            end
            ST_RANK_CMP:
            begin
                // rank = number of elements that sort before the pivot
                rank_next    = rank_reg + AW'(cmp_before);
                val_rd_addr  = cmp_idx_reg + AW'(1);
                cmp_idx_next = cmp_idx_reg + AW'(1);
            end
            ST_RANK_WRITE:
            begin
                sort_wr_en = 1'b1;
                if (pivot_idx_reg == last_pos_reg)
                begin
                    emit_k_next = '0;
                end
                else
                begin
                    pivot_idx_next = pivot_idx_reg + AW'(1);
                end
            end
            ST_EMIT_RD:
            begin
                sort_rd_en = 1'b1;
            end
            ST_EMIT_SHOW:
            begin
                out_valid = 1'b1;
                // valid is high here, so no stall means the item goes out
                if (!out_stall)
                begin
                    if (emit_final)
                    begin
                        // run done, next item opens a new set
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        emit_k_next = emit_k_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // result item: payload stays put while the item waits
    assign out_data.index        = IDX_W'(sort_rd_data_reg[AW+VALUE_W-1:VALUE_W]);
    assign out_data.sorted_value = sort_rd_data_reg[VALUE_W-1:0];
    assign out_data.final_res    = emit_final;
    assign out_data.overflow     = ovf_reg;

    // ------------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (val_wr_en)
        begin
            value_mem[val_wr_addr] <= in_data.value;
        end
        val_rd_data_reg <= value_mem[val_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (sort_wr_en)
        begin
            sort_mem[rank_reg] <= {pivot_idx_reg, pivot_val_reg};
        end
        if (sort_rd_en)
        begin
            sort_rd_data_reg <= sort_mem[sort_rd_addr];
        end
    end

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            desc_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cfg_wr_en)
            begin
                desc_reg <= cfg_wr_data;
            end
        end
    end

    // working registers of the sequencer
    always_ff @(posedge clk)
    begin
        last_pos_reg  <= last_pos_next;
        pivot_idx_reg <= pivot_idx_next;
        pivot_val_reg <= pivot_val_next;
        cmp_idx_reg   <= cmp_idx_next;
        rank_reg      <= rank_next;
        emit_k_reg    <= emit_k_next;
    end

endmodule
